[rtl/core/ecf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecf_pkg
// shared constants and codes for the euler circuit finder
// ----------------------------------------------------------------------------
package ecf_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int STACK_DEPTH  = 29;

  localparam int VERTEX_W = 3;
  localparam int COUNT_W  = 4;
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int STK_IW   = $clog2(STACK_DEPTH);
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 4;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ODD       = 2'd1,
    STATUS_ASYM      = 2'd2,
    STATUS_BAD_START = 2'd3
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_VERTEX_COUNT = 1'd0,
    REG_START_VERTEX = 1'd1
  } reg_index_t;

  localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RST = COUNT_W'(MAX_VERTICES);
  localparam logic [VERTEX_W-1:0] START_VERTEX_RST = VERTEX_W'(1);

endpackage

[rtl/core/euler_circuit_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_circuit_finder
// loads an adjacency matrix row by row, checks it, then walks an euler circuit
// ----------------------------------------------------------------------------
// channel  dir  signals                          contents
// s_       in   s_tvalid s_tready s_tdata[7:0]   row_bits
// m_       out  m_tvalid m_tready m_tdata[7:0]   [2:0] vertex, [4:3] status
//                                   m_tlast        last
// cfg_     in   cfg_valid cfg_ready cfg_index    0 vertex_count, 1 start_vertex
//                                   cfg_data[3:0]
//
// rows are taken one per cycle; the item that completes the load moves to a
// check state, then the walk state either follows one edge or pops a vertex
// and passes it to the emit state for output, all on a single lowest-neighbor
// search unit. s_tready is low from the completing row until the last result
// is taken. output stalls hold the walk. rst is synchronous and clears the
// row counter, stack pointer and registers to their defaults.
// ----------------------------------------------------------------------------
module euler_circuit_finder
  import ecf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] row_bits
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [2:0] vertex, [4:3] status, [7:5] zero
  output logic              m_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  typedef enum logic [1:0] {ST_LOAD, ST_CHECK, ST_WALK, ST_EMIT} state_t;

  state_t                state;
  logic [COUNT_W-1:0]    vertex_count;
  logic [VERTEX_W-1:0]   start_vertex;
  logic [COUNT_W-1:0]    row_counter;
  logic [SP_W-1:0]       stack_pointer;
  row_t                  adjacency [MAX_VERTICES];
  logic [VERTEX_W-1:0]   walk_stack [STACK_DEPTH];
  logic [VERTEX_W-1:0]   out_vertex;
  status_t               out_status;
  logic                  out_last;

  logic [COUNT_W-1:0]    n_eff;
  row_t                  mask;
  logic [VERTEX_W-1:0]   load_idx;
  logic                  load_done;
  row_t                  masked [MAX_VERTICES];
  logic                  asym;
  logic                  odd;
  logic                  bad_start;
  logic [VERTEX_W-1:0]   top;
  row_t                  top_row;
  logic [VERTEX_W-1:0]   nbr;
  logic                  stack_full;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_LOAD);
  assign m_tvalid  = (state == ST_EMIT);
  assign m_tdata   = {3'b000, out_status, out_vertex};
  assign m_tlast   = out_last;

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (vertex_count > COUNT_W'(MAX_VERTICES)) begin
      n_eff = COUNT_W'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (COUNT_W'(i) < n_eff);
    end
    if (row_counter >= COUNT_W'(MAX_VERTICES)) begin
      load_idx = VERTEX_W'(MAX_VERTICES - 1);
    end else begin
      load_idx = row_counter[VERTEX_W-1:0];
    end
    load_done = !((COUNT_W'(load_idx) + COUNT_W'(1)) < n_eff);
  end

  // re-mask and matrix checks, all rows in parallel
  always_comb begin
    asym = 1'b0;
    odd  = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      masked[i]    = mask[i] ? (adjacency[i] & mask) : '0;
      masked[i][i] = 1'b0;
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      odd = odd | (^masked[i]);
      for (int j = 0; j < MAX_VERTICES; j++) begin
        asym = asym | (masked[i][j] != masked[j][i]);
      end
    end
    bad_start = (COUNT_W'(start_vertex) >= n_eff);
  end

  // walk step: top of stack and its lowest remaining neighbor
  always_comb begin
    top        = walk_stack[STK_IW'(stack_pointer - SP_W'(1))];
    top_row    = adjacency[top];
    stack_full = (stack_pointer >= SP_W'(STACK_DEPTH));
    nbr        = '0;
    for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
      if (top_row[j]) begin
        nbr = VERTEX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      vertex_count  <= VERTEX_COUNT_RST;
      start_vertex  <= START_VERTEX_RST;
      row_counter   <= '0;
      stack_pointer <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VERTEX_COUNT: vertex_count <= cfg_data;
          REG_START_VERTEX: start_vertex <= cfg_data[VERTEX_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            adjacency[load_idx] <= s_tdata[MAX_VERTICES-1:0] & mask
                                   & ~(row_t'(1) << load_idx);
            if (load_done) begin
              row_counter <= '0;
              state       <= ST_CHECK;
            end else begin
              row_counter <= COUNT_W'(load_idx) + COUNT_W'(1);
            end
          end
        end
        ST_CHECK: begin
          for (int i = 0; i < MAX_VERTICES; i++) begin
            adjacency[i] <= masked[i];
          end
          out_vertex <= '0;
          out_last   <= 1'b1;
          if (asym) begin
            out_status <= STATUS_ASYM;
            state      <= ST_EMIT;
          end else if (odd) begin
            out_status <= STATUS_ODD;
            state      <= ST_EMIT;
          end else if (bad_start) begin
            out_status <= STATUS_BAD_START;
            state      <= ST_EMIT;
          end else begin
            walk_stack[0] <= start_vertex;
            stack_pointer <= SP_W'(1);
            state         <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (top_row == '0 || stack_full) begin
            stack_pointer <= stack_pointer - SP_W'(1);
            out_vertex    <= top;
            out_status    <= STATUS_OK;
            out_last      <= (stack_pointer == SP_W'(1));
            state         <= ST_EMIT;
          end else begin
            adjacency[top][nbr]                 <= 1'b0;
            adjacency[nbr][top]                 <= 1'b0;
            walk_stack[STK_IW'(stack_pointer)]  <= nbr;
            stack_pointer                       <= stack_pointer + SP_W'(1);
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            state <= out_last ? ST_LOAD : ST_WALK;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    stack_pointer <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (stack_pointer != '0))
    else $error("walk with empty stack");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != STATUS_OK) |-> m_tlast)
    else $error("error result not flagged last");

  a_return_load: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready for rows after last item");

endmodule
